### rtl/core/tbzcd_pkg.sv
package tbzcd_pkg;

  typedef struct packed {
    logic signed [15:0] left_pcm;
    logic signed [15:0] right_pcm;
    logic               chunk_end;
  } in_t;

  typedef struct packed {
    logic        result_kind;
    logic [15:0] frequency_hz;
    logic [6:0]  char_code;
    logic        stored;
  } out_t;

  typedef struct packed {
    logic accept;
    logic mul_load;
    logic div_iter;
    logic code_load;
    logic out_msg;
    logic out_est;
  } cmd_t;

  typedef struct packed {
    logic msg_end;
    logic est_req;
    logic div_last;
  } sts_t;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] CFG_START_RUN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AMP_THR   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_QUIET_RUN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP      = 3'd4;

  localparam logic [12:0] START_RUN_RST = 13'd40;
  localparam logic [14:0] AMP_THR_RST   = 15'd1000;
  localparam logic [10:0] QUIET_RUN_RST = 11'd10;
  localparam logic [16:0] RATE_RST      = 17'd48000;
  localparam logic [9:0]  STEP_RST      = 10'd150;

  localparam logic [12:0] START_RUN_MAX    = 13'd8191;
  localparam logic [10:0] QUIET_RUN_MAX    = 11'd2047;
  localparam logic [12:0] MAX_CHUNK_FRAMES = 13'd4096;
  localparam logic [5:0]  MAX_CODES        = 6'd50;

  localparam logic [6:0]  UNKNOWN_CODE = 7'd63;
  localparam logic [15:0] CODE_LOW     = 16'd32;
  localparam logic [15:0] CODE_HIGH    = 16'd126;

  localparam int DIV_W = 30;
  localparam logic [4:0] DIV_LAST_CNT  = 5'd29;
  localparam logic [4:0] CODE_START_CNT = 5'd14;

  localparam logic RK_FREQ = 1'b0;
  localparam logic RK_MSG  = 1'b1;

endpackage

### rtl/core/tbzcd_ctrl.sv
module tbzcd_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  tbzcd_pkg::sts_t sts,
  output tbzcd_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MSG,
    S_MUL,
    S_DIVF,
    S_CODE,
    S_DIVC,
    S_EST
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r;
  logic   out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid) begin
          if (sts.msg_end) begin
            state_nxt = S_MSG;
          end else if (sts.est_req) begin
            state_nxt = S_MUL;
          end
        end
      end
      S_MSG: begin
        if (out_free) begin
          cmd.out_msg = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      S_MUL: begin
        cmd.mul_load = 1'b1;
        state_nxt    = S_DIVF;
      end
      S_DIVF: begin
        cmd.div_iter = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_CODE;
        end
      end
      S_CODE: begin
        cmd.code_load = 1'b1;
        state_nxt     = S_DIVC;
      end
      S_DIVC: begin
        cmd.div_iter = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_EST;
        end
      end
      S_EST: begin
        if (out_free) begin
          cmd.out_est = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.out_msg || cmd.out_est) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

### rtl/core/tbzcd_dp.sv
module tbzcd_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [tbzcd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tbzcd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  tbzcd_pkg::in_t                       in_data,
  output tbzcd_pkg::out_t                      out_data,
  input  tbzcd_pkg::cmd_t                      cmd,
  output tbzcd_pkg::sts_t                      sts
);

  logic [12:0] start_len_r;
  logic [14:0] amp_thr_r;
  logic [10:0] quiet_len_r;
  logic [16:0] rate_r;
  logic [9:0]  step_r;

  logic        armed_r, armed_nxt;
  logic        in_burst_r, in_burst_nxt;
  logic [12:0] start_run_r, start_run_nxt;
  logic [15:0] prior_r, prior_nxt;
  logic [10:0] quiet_run_r, quiet_run_nxt;
  logic [12:0] cross_r, cross_nxt;
  logic [12:0] samples_r, samples_nxt;
  logic [5:0]  stored_cnt_r;

  logic [12:0] op_cross_r;
  logic [12:0] op_samples_r;

  logic [tbzcd_pkg::DIV_W-1:0] quo_r;
  logic [13:0] rem_r;
  logic [13:0] dvsr_r;
  logic [4:0]  cnt_r;
  logic [15:0] freq_r;
  logic [15:0] div_diff;
  logic [15:0] freq_sat;
  logic [15:0] code_q;
  logic [6:0]  code_val;

  tbzcd_pkg::out_t out_r;

  logic signed [15:0] left_s;
  logic signed [15:0] right_s;
  logic [16:0] left_ext;
  logic [16:0] mag;
  logic        loud;
  logic [12:0] sr_tmp;
  logic [10:0] q_tmp;
  logic        msg_end;

  function automatic logic [12:0] chunk_up(input logic [12:0] c);
    chunk_up = (c < tbzcd_pkg::MAX_CHUNK_FRAMES) ? c + 13'd1 : c;
  endfunction

  assign left_s   = in_data.left_pcm;
  assign right_s  = in_data.right_pcm;
  assign left_ext = {left_s[15], left_s};
  assign mag      = left_s[15] ? (17'd0 - left_ext) : left_ext;
  assign loud     = mag > {2'b00, amp_thr_r};

  always_comb begin
    armed_nxt     = armed_r;
    in_burst_nxt  = in_burst_r;
    start_run_nxt = start_run_r;
    prior_nxt     = prior_r;
    quiet_run_nxt = quiet_run_r;
    cross_nxt     = cross_r;
    samples_nxt   = samples_r;
    msg_end       = 1'b0;
    sr_tmp        = '0;
    q_tmp         = '0;
    if (armed_r) begin
      if (left_s > right_s) begin
        sr_tmp = (start_run_r < tbzcd_pkg::START_RUN_MAX) ? start_run_r + 13'd1 : start_run_r;
      end
      start_run_nxt = sr_tmp;
      if (sr_tmp >= start_len_r) begin
        armed_nxt = 1'b0;
      end
    end else if (!in_burst_r) begin
      if (loud) begin
        in_burst_nxt = 1'b1;
        samples_nxt  = chunk_up(samples_r);
        prior_nxt    = left_s;
      end
    end else begin
      samples_nxt = chunk_up(samples_r);
      if (prior_r[15] != left_s[15]) begin
        cross_nxt = chunk_up(cross_r);
      end
      prior_nxt = left_s;
      if (!loud) begin
        q_tmp = (quiet_run_r < tbzcd_pkg::QUIET_RUN_MAX) ? quiet_run_r + 11'd1 : quiet_run_r;
        quiet_run_nxt = q_tmp;
        if (q_tmp >= quiet_len_r) begin
          in_burst_nxt  = 1'b0;
          quiet_run_nxt = '0;
          armed_nxt     = 1'b1;
          msg_end       = 1'b1;
        end
      end else begin
        quiet_run_nxt = '0;
      end
    end
  end

  assign sts.msg_end  = msg_end;
  assign sts.est_req  = in_data.chunk_end && in_burst_nxt && (samples_nxt != 13'd0);
  assign sts.div_last = (cnt_r == tbzcd_pkg::DIV_LAST_CNT);

  assign div_diff = {1'b0, rem_r, quo_r[tbzcd_pkg::DIV_W-1]} - {2'b00, dvsr_r};
  assign freq_sat = (|quo_r[tbzcd_pkg::DIV_W-1:16]) ? 16'hFFFF : quo_r[15:0];
  assign code_q   = quo_r[15:0];
  assign code_val = ((step_r != 10'd0) && (code_q >= tbzcd_pkg::CODE_LOW)
                     && (code_q <= tbzcd_pkg::CODE_HIGH)) ? code_q[6:0]
                                                           : tbzcd_pkg::UNKNOWN_CODE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_len_r  <= tbzcd_pkg::START_RUN_RST;
      amp_thr_r    <= tbzcd_pkg::AMP_THR_RST;
      quiet_len_r  <= tbzcd_pkg::QUIET_RUN_RST;
      rate_r       <= tbzcd_pkg::RATE_RST;
      step_r       <= tbzcd_pkg::STEP_RST;
      armed_r      <= 1'b1;
      in_burst_r   <= 1'b0;
      start_run_r  <= '0;
      prior_r      <= '0;
      quiet_run_r  <= '0;
      cross_r      <= '0;
      samples_r    <= '0;
      stored_cnt_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          tbzcd_pkg::CFG_START_RUN: start_len_r <= cfg_wdata[12:0];
          tbzcd_pkg::CFG_AMP_THR:   amp_thr_r   <= cfg_wdata[14:0];
          tbzcd_pkg::CFG_QUIET_RUN: quiet_len_r <= cfg_wdata[10:0];
          tbzcd_pkg::CFG_RATE:      rate_r      <= cfg_wdata;
          tbzcd_pkg::CFG_STEP:      step_r      <= cfg_wdata[9:0];
          default: ;
        endcase
      end
      if (cmd.accept) begin
        armed_r     <= armed_nxt;
        in_burst_r  <= in_burst_nxt;
        prior_r     <= prior_nxt;
        quiet_run_r <= quiet_run_nxt;
        if (in_data.chunk_end) begin
          start_run_r <= '0;
          cross_r     <= '0;
          samples_r   <= '0;
        end else begin
          start_run_r <= start_run_nxt;
          cross_r     <= cross_nxt;
          samples_r   <= samples_nxt;
        end
      end
      if (cmd.out_est && (stored_cnt_r < tbzcd_pkg::MAX_CODES)) begin
        stored_cnt_r <= stored_cnt_r + 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_cross_r   <= cross_nxt;
      op_samples_r <= samples_nxt;
    end
    if (cmd.mul_load) begin
      quo_r  <= {17'd0, op_cross_r} * {13'd0, rate_r};
      rem_r  <= '0;
      dvsr_r <= {op_samples_r, 1'b0};
      cnt_r  <= '0;
    end else if (cmd.code_load) begin
      freq_r <= freq_sat;
      quo_r  <= {freq_sat, 14'd0};
      rem_r  <= '0;
      dvsr_r <= {4'd0, step_r};
      cnt_r  <= tbzcd_pkg::CODE_START_CNT;
    end else if (cmd.div_iter) begin
      cnt_r <= cnt_r + 5'd1;
      if (!div_diff[15]) begin
        rem_r <= div_diff[13:0];
        quo_r <= {quo_r[tbzcd_pkg::DIV_W-2:0], 1'b1};
      end else begin
        rem_r <= {rem_r[12:0], quo_r[tbzcd_pkg::DIV_W-1]};
        quo_r <= {quo_r[tbzcd_pkg::DIV_W-2:0], 1'b0};
      end
    end
    if (cmd.out_msg) begin
      out_r.result_kind  <= tbzcd_pkg::RK_MSG;
      out_r.frequency_hz <= '0;
      out_r.char_code    <= '0;
      out_r.stored       <= 1'b0;
    end else if (cmd.out_est) begin
      out_r.result_kind  <= tbzcd_pkg::RK_FREQ;
      out_r.frequency_hz <= freq_r;
      out_r.char_code    <= code_val;
      out_r.stored       <= (stored_cnt_r < tbzcd_pkg::MAX_CODES);
    end
  end

  assign out_data = out_r;

endmodule

### rtl/core/tone_burst_zero_cross_decoder.sv
// Tone-burst zero-crossing decoder.
// Input channel in_valid/in_stall/in_data carries one stereo sample pair
// per beat with a chunk-end mark; a beat is taken when in_valid is high
// and in_stall is low. Result channel out_valid/out_stall/out_data carries
// message-end and per-chunk frequency/code results through an output
// register, so a result waiting on out_stall does not hold up input.
// Configuration: cfg_we, cfg_index, cfg_wdata write one register per edge;
// write only while the block is idle.
// Flow: a pair that gives no result leaves the block idle, ready to take
// another pair. A pair that closes a burst passes the message state, which
// registers its result. A chunk end inside a burst runs one multiply, a
// 30-step quotient for the frequency and 16 steps for the code on one
// shared one-bit-per-cycle divider; state S_EST then registers its result.
// in_stall stays high while that work runs, and while a new result waits
// for the output register to free up under out_stall.
// Reset (rst_n low at a clock edge) rearms the block, clears counters,
// restores default registers and drops out_valid.
module tone_burst_zero_cross_decoder (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [tbzcd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tbzcd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  tbzcd_pkg::in_t                   in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output tbzcd_pkg::out_t                  out_data
);

  tbzcd_pkg::cmd_t cmd;
  tbzcd_pkg::sts_t sts;

  tbzcd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  tbzcd_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

### bench/tb_tone_burst_zero_cross_decoder.sv
`timescale 1ns / 100ps

module tb_tone_burst_zero_cross_decoder;

  logic                             clk       = 1'b0;
  logic                             rst_n     = 1'b0;
  logic                             cfg_we    = 1'b0;
  logic [tbzcd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [tbzcd_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                             in_valid  = 1'b0;
  logic                             in_stall;
  tbzcd_pkg::in_t                   in_data   = '0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  tbzcd_pkg::out_t                  out_data;

  tone_burst_zero_cross_decoder uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  tbzcd_pkg::in_t  sample_queue[$];
  tbzcd_pkg::out_t decode_due[$];
  int   mismatch_count = 0;
  int   idle_pct       = 0;
  int   stall_pct      = 0;
  int   feed_gap       = 0;
  int   hold_left      = 0;
  int   phase_items    = 0;

  int lead_need  = tbzcd_pkg::START_RUN_RST;
  int loud_level = tbzcd_pkg::AMP_THR_RST;
  int hush_need  = tbzcd_pkg::QUIET_RUN_RST;
  int rate_hz    = tbzcd_pkg::RATE_RST;
  int step_hz    = tbzcd_pkg::STEP_RST;

  bit hunting     = 1'b1;
  bit tone_on     = 1'b0;
  int lead_count  = 0;
  int last_left   = 0;
  int hush_count  = 0;
  int cross_count = 0;
  int span_count  = 0;
  int kept_count  = 0;

  task automatic decode_pair(input tbzcd_pkg::in_t beat);
    int              l, r, mag;
    longint          freq, code;
    tbzcd_pkg::out_t res;
    l   = $signed(beat.left_pcm);
    r   = $signed(beat.right_pcm);
    mag = (l < 0) ? -l : l;
    if (hunting) begin
      if (l > r) begin
        if (lead_count < tbzcd_pkg::START_RUN_MAX) lead_count++;
      end else begin
        lead_count = 0;
      end
      if (lead_count >= lead_need) hunting = 1'b0;
    end else if (!tone_on) begin
      if (mag > loud_level) begin
        tone_on = 1'b1;
        if (span_count < tbzcd_pkg::MAX_CHUNK_FRAMES) span_count++;
        last_left = l;
      end
    end else begin
      if (span_count < tbzcd_pkg::MAX_CHUNK_FRAMES) span_count++;
      if (((last_left >= 0) != (l >= 0)) && cross_count < tbzcd_pkg::MAX_CHUNK_FRAMES)
        cross_count++;
      last_left = l;
      if (mag <= loud_level) begin
        if (hush_count < tbzcd_pkg::QUIET_RUN_MAX) hush_count++;
        if (hush_count >= hush_need) begin
          tone_on    = 1'b0;
          hush_count = 0;
          hunting    = 1'b1;
          res             = '0;
          res.result_kind = tbzcd_pkg::RK_MSG;
          decode_due.insert(decode_due.size(), res);
        end
      end else begin
        hush_count = 0;
      end
    end
    if (beat.chunk_end) begin
      if (tone_on && span_count != 0) begin
        freq = (longint'(cross_count) * rate_hz) / (2 * span_count);
        if (freq > 65535) freq = 65535;
        code = tbzcd_pkg::UNKNOWN_CODE;
        if (step_hz != 0 && freq / step_hz >= tbzcd_pkg::CODE_LOW
            && freq / step_hz <= tbzcd_pkg::CODE_HIGH)
          code = freq / step_hz;
        res.result_kind  = tbzcd_pkg::RK_FREQ;
        res.frequency_hz = freq[15:0];
        res.char_code    = code[6:0];
        res.stored       = (kept_count < tbzcd_pkg::MAX_CODES);
        if (res.stored) kept_count++;
        decode_due.insert(decode_due.size(), res);
      end
      lead_count  = 0;
      cross_count = 0;
      span_count  = 0;
    end
  endtask

  task automatic flag_mismatch(input string what);
    mismatch_count++;
    $display("%0t ns: mismatch: %s", $time, what);
  endtask

  task automatic check_decode(input tbzcd_pkg::out_t got);
    tbzcd_pkg::out_t want;
    if (decode_due.size() == 0) begin
      flag_mismatch($sformatf("unexpected result kind=%0d freq=%0d code=%0d stored=%0d",
                              got.result_kind, got.frequency_hz, got.char_code, got.stored));
    end else begin
      want = decode_due.pop_front();
      if (got.result_kind !== want.result_kind)
        flag_mismatch($sformatf("result_kind got %0d want %0d",
                                got.result_kind, want.result_kind));
      if (got.frequency_hz !== want.frequency_hz)
        flag_mismatch($sformatf("frequency_hz got %0d want %0d",
                                got.frequency_hz, want.frequency_hz));
      if (got.char_code !== want.char_code)
        flag_mismatch($sformatf("char_code got %0d want %0d", got.char_code, want.char_code));
      if (got.stored !== want.stored)
        flag_mismatch($sformatf("stored got %0d want %0d", got.stored, want.stored));
    end
  endtask

  // feed beats from the queue, holding each until taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) decode_pair(in_data);
      if (!in_valid || !in_stall) begin
        if (feed_gap != 0) begin
          feed_gap <= feed_gap - 1;
          in_valid <= 1'b0;
        end else if (sample_queue.size() != 0) begin
          in_data  <= sample_queue.pop_front();
          in_valid <= 1'b1;
          if (idle_pct != 0 && $urandom_range(99, 0) < idle_pct)
            feed_gap <= $urandom_range(15, 1);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_decode(out_data);
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (stall_pct != 0 && $urandom_range(99, 0) < stall_pct) begin
        hold_left <= $urandom_range(14, 0);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic write_reg(input logic [tbzcd_pkg::CFG_IDX_W-1:0] idx, input int val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[tbzcd_pkg::CFG_DATA_W-1:0];
    case (idx)
      tbzcd_pkg::CFG_START_RUN: lead_need  = val;
      tbzcd_pkg::CFG_AMP_THR:   loud_level = val;
      tbzcd_pkg::CFG_QUIET_RUN: hush_need  = val;
      tbzcd_pkg::CFG_RATE:      rate_hz    = val;
      tbzcd_pkg::CFG_STEP:      step_hz    = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_pair(input int l, input int r, input bit last);
    tbzcd_pkg::in_t b;
    b.left_pcm  = l[15:0];
    b.right_pcm = r[15:0];
    b.chunk_end = last;
    sample_queue.insert(sample_queue.size(), b);
    phase_items++;
  endtask

  function automatic int quiet_left();
    int v;
    v = $urandom_range(loud_level, 0);
    return $urandom_range(1, 0) ? -v : v;
  endfunction

  function automatic int loud_left(input bit neg);
    int v;
    if (loud_level >= 32767 || (neg && $urandom_range(7, 0) == 0)) return -32768;
    v = $urandom_range(32767, loud_level + 1);
    return neg ? -v : v;
  endfunction

  // start pattern, burst tone with chunk ends, then a quiet tail
  task automatic queue_message();
    int lead, hlf, ph, span, l;
    lead = lead_need + $urandom_range(3, 0);
    for (int i = 0; i < lead; i++) begin
      l = int'($urandom_range(65534, 0)) - 32767;
      queue_pair(l, int'($urandom_range(l + 32767, 0)) - 32768, $urandom_range(39, 0) == 0);
    end
    for (int i = $urandom_range(2, 0); i > 0; i--) queue_pair(quiet_left(), $urandom, 1'b0);
    hlf  = $urandom_range(12, 1);
    ph   = $urandom_range(2 * hlf - 1, 0);
    span = $urandom_range(100, 4);
    for (int t = 0; t < span; t++) begin
      if ($urandom_range(9, 0) == 0) l = quiet_left();
      else l = loud_left(((t + ph) / hlf) % 2);
      queue_pair(l, $urandom, $urandom_range(11, 0) == 0);
    end
    for (int i = hush_need + $urandom_range(2, 0); i > 0; i--)
      queue_pair(quiet_left(), $urandom, $urandom_range(11, 0) == 0);
  endtask

  task automatic queue_noise();
    for (int i = $urandom_range(10, 1); i > 0; i--)
      queue_pair($urandom, $urandom, $urandom_range(7, 0) == 0);
  endtask

  task automatic settle();
    while (sample_queue.size() != 0 || in_valid || decode_due.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic run_phase(input int sr, thr, qr, rate, step, idle, stall, budget,
                           input bit noise_only);
    write_reg(tbzcd_pkg::CFG_START_RUN, sr);
    write_reg(tbzcd_pkg::CFG_AMP_THR, thr);
    write_reg(tbzcd_pkg::CFG_QUIET_RUN, qr);
    write_reg(tbzcd_pkg::CFG_RATE, rate);
    write_reg(tbzcd_pkg::CFG_STEP, step);
    idle_pct    = idle;
    stall_pct   = stall;
    phase_items = 0;
    while (phase_items < budget) begin
      if (noise_only || $urandom_range(4, 0) == 0) queue_noise();
      else queue_message();
    end
    settle();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    run_phase(2, 1000, 3, 48000, 150, 25, 20, 0, 1'b0);
    queue_pair(32767, -32768, 0);
    queue_pair(-32768, 32767, 0);
    queue_pair(32767, -32768, 0);
    queue_pair(100, -100, 0);
    queue_pair(500, 0, 0);
    queue_pair(-32768, 0, 0);
    queue_pair(32767, -1, 0);
    queue_pair(-2000, 0, 0);
    queue_pair(2000, 0, 1);
    queue_pair(0, 0, 0);
    queue_pair(1000, 0, 0);
    queue_pair(-1, 0, 0);
    queue_pair(-1, -2, 1);
    settle();

    // zero start length, zero quiet length, zero step; burst closes on a chunk end
    run_phase(0, 1000, 0, 48000, 0, 25, 20, 0, 1'b0);
    queue_pair(0, 0, 0);
    queue_pair(-1200, 5, 0);
    queue_pair(3000, 5, 1);
    queue_pair(2500, 0, 0);
    queue_pair(10, 0, 1);
    queue_pair(-32768, -32768, 0);
    queue_pair(0, 0, 1);
    settle();

    run_phase(40, 1000, 10, 48000, 150, 20, 10, 400, 1'b0);
    run_phase(1, 0, 1, 8000, 1, 30, 15, 200, 1'b0);
    run_phase(3, 20000, 4, 96000, 1000, 10, 25, 250, 1'b0);
    run_phase(8191, 32767, 2047, 131071, 1023, 20, 20, 40, 1'b1);
    run_phase(1, 32767, 2, 12345, 7, 15, 10, 160, 1'b0);
    run_phase(0, 500, 0, 0, 0, 20, 20, 200, 1'b0);
    run_phase(2, 1500, 3, 131071, 1023, 25, 5, 250, 1'b0);
    run_phase(5, 3000, 6, 44100, 100, 0, 0, 400, 1'b0);

    if (mismatch_count == 0) begin
      $display("tb_tone_burst_zero_cross_decoder: done, clean");
    end else begin
      $display("tb_tone_burst_zero_cross_decoder: done, errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_tone_burst_zero_cross_decoder: done, errors");
    $finish;
  end

endmodule
